// ----- src/rdbp_pkg.sv -----
// ----------------------------------------------------------------------------
// rdbp_pkg
// Shared constants and types for the rotary detent and button pulser.
// ----------------------------------------------------------------------------
package rdbp_pkg;

    // Number of encoder lanes; valid range 1 to 10.
    localparam int ENCODER_COUNT = 5;

    // Widths fixed by the input and output fields.
    localparam int LEVEL_W    = 5;
    localparam int TIME_W     = 32;
    localparam int MASK_W     = 32;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;

    // Configuration register widths.
    localparam int EDGE_DB_W   = 8;
    localparam int PRESS_DB_W  = 10;
    localparam int PULSE_LEN_W = 10;
    localparam int FIRST_BIT_W = 5;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 2;

    // Buttons per encoder: clockwise, counterclockwise, push.
    localparam int BTN_PER_LANE = 3;
    localparam int BTN_CW       = 0;
    localparam int BTN_CCW      = 1;
    localparam int BTN_PRESS    = 2;

    // Highest mask position a lane can address, and the width to hold it.
    localparam int MAX_POS = (1 << FIRST_BIT_W) - 1 + BTN_PER_LANE * (ENCODER_COUNT - 1)
                             + BTN_PER_LANE - 1;
    localparam int POS_W   = $clog2(MAX_POS + 1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_EDGE_DB   = 2'd0,
        CFG_PRESS_DB  = 2'd1,
        CFG_PULSE_LEN = 2'd2,
        CFG_FIRST_BIT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [EDGE_DB_W-1:0]   edge_db;
        logic [PRESS_DB_W-1:0]  press_db;
        logic [PULSE_LEN_W-1:0] pulse_len;
        logic [FIRST_BIT_W-1:0] first_bit;
    } cfg_t;

    // Per-lane request on its three buttons: CW, CCW, press from bit 0 up.
    // A set wins over a clear of the same button.
    typedef struct packed {
        logic [BTN_PER_LANE-1:0] set;
        logic [BTN_PER_LANE-1:0] clr;
    } lane_result_t;

endpackage

// ----- src/rdbp_lane.sv -----
// ----------------------------------------------------------------------------
// rdbp_lane
// One encoder: edge debounce, detent tracking, pulse timing and push-button
// debounce. Reports which of its three buttons to set or clear this poll.
// ----------------------------------------------------------------------------
module rdbp_lane
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            clk_lvl,
    input  logic                            dt_lvl,
    input  logic                            btn_lvl,
    input  logic [rdbp_pkg::TIME_W-1:0]     now_ms,
    input  rdbp_pkg::cfg_t                  cfg,
    output rdbp_pkg::lane_result_t          result
);
    import rdbp_pkg::*;

    logic              clk_seen_reg,  clk_seen_next;
    logic              dt_seen_reg,   dt_seen_next;
    logic              press_seen_reg, press_seen_next;
    logic              turn_reg,      turn_next;
    logic              turn_cw_reg,   turn_cw_next;
    logic [TIME_W-1:0] edge_stamp_reg,  edge_stamp_next;
    logic [TIME_W-1:0] press_stamp_reg, press_stamp_next;
    logic [TIME_W-1:0] pulse_end_reg,   pulse_end_next;
    logic              active_reg,    active_next;
    logic              ccw_reg,       ccw_next;

    logic [TIME_W-1:0] edge_elapsed;
    logic [TIME_W-1:0] press_elapsed;
    logic [TIME_W-1:0] pulse_diff;
    logic              edge_ok;
    logic              expired;
    logic              still_active;
    logic              turn_start;
    logic              detent_done;
    logic              press_change;
    logic              new_ccw;

    assign edge_elapsed  = now_ms - edge_stamp_reg;
    assign press_elapsed = now_ms - press_stamp_reg;
    assign pulse_diff    = now_ms - pulse_end_reg;

    assign edge_ok      = edge_elapsed > TIME_W'(cfg.edge_db);
    // Pulse is over once now has reached the end time, wrap-safe.
    assign expired      = active_reg && !pulse_diff[TIME_W-1];
    assign still_active = active_reg && !expired;
    assign turn_start   = edge_ok && !clk_lvl && clk_seen_reg && !turn_reg;
    assign detent_done  = edge_ok && !turn_start && clk_lvl && dt_lvl && turn_reg
                          && (!clk_seen_reg || !dt_seen_reg);
    assign press_change = (btn_lvl != press_seen_reg)
                          && (press_elapsed > TIME_W'(cfg.press_db));
    assign new_ccw      = !turn_cw_reg;

    always_comb
    begin
        result.set[BTN_CW]    = detent_done && !new_ccw;
        result.set[BTN_CCW]   = detent_done && new_ccw;
        result.set[BTN_PRESS] = press_change && !btn_lvl;
        result.clr[BTN_CW]    = (expired || (detent_done && still_active)) && !ccw_reg;
        result.clr[BTN_CCW]   = (expired || (detent_done && still_active)) && ccw_reg;
        result.clr[BTN_PRESS] = press_change && btn_lvl;
    end

    always_comb
    begin
        clk_seen_next    = clk_seen_reg;
        dt_seen_next     = dt_seen_reg;
        press_seen_next  = press_seen_reg;
        turn_next        = turn_reg;
        turn_cw_next     = turn_cw_reg;
        edge_stamp_next  = edge_stamp_reg;
        press_stamp_next = press_stamp_reg;
        pulse_end_next   = pulse_end_reg;
        active_next      = active_reg;
        ccw_next         = ccw_reg;

        if (expired)
        begin
            active_next = 1'b0;
        end
        if (turn_start)
        begin
            turn_cw_next    = dt_lvl;
            turn_next       = 1'b1;
            edge_stamp_next = now_ms;
        end
        if (detent_done)
        begin
            ccw_next        = new_ccw;
            active_next     = 1'b1;
            pulse_end_next  = now_ms + TIME_W'(cfg.pulse_len);
            turn_next       = 1'b0;
            turn_cw_next    = 1'b0;
            edge_stamp_next = now_ms;
        end
        if (edge_ok)
        begin
            clk_seen_next = clk_lvl;
            dt_seen_next  = dt_lvl;
        end
        if (press_change)
        begin
            press_stamp_next = now_ms;
            press_seen_next  = btn_lvl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_seen_reg    <= 1'b1;
            dt_seen_reg     <= 1'b1;
            press_seen_reg  <= 1'b1;
            turn_reg        <= 1'b0;
            turn_cw_reg     <= 1'b0;
            edge_stamp_reg  <= '0;
            press_stamp_reg <= '0;
            pulse_end_reg   <= '0;
            active_reg      <= 1'b0;
            ccw_reg         <= 1'b0;
        end
        else if (en)
        begin
            clk_seen_reg    <= clk_seen_next;
            dt_seen_reg     <= dt_seen_next;
            press_seen_reg  <= press_seen_next;
            turn_reg        <= turn_next;
            turn_cw_reg     <= turn_cw_next;
            edge_stamp_reg  <= edge_stamp_next;
            press_stamp_reg <= press_stamp_next;
            pulse_end_reg   <= pulse_end_next;
            active_reg      <= active_next;
            ccw_reg         <= ccw_next;
        end
    end

endmodule

// ----- src/rdbp_merge.sv -----
// ----------------------------------------------------------------------------
// rdbp_merge
// Places each lane's button requests at their mask positions and applies
// them to the current mask.
// ----------------------------------------------------------------------------
module rdbp_merge
(
    input  rdbp_pkg::lane_result_t                 results [rdbp_pkg::ENCODER_COUNT],
    input  logic [rdbp_pkg::FIRST_BIT_W-1:0]       first_bit,
    input  logic [rdbp_pkg::MASK_W-1:0]            mask_cur,
    output logic [rdbp_pkg::MASK_W-1:0]            mask_next
);
    import rdbp_pkg::*;

    logic [MASK_W-1:0] set_vec;
    logic [MASK_W-1:0] clr_vec;

    // Lanes own disjoint bits, so their requests simply OR together.
    always_comb
    begin
        logic [POS_W-1:0] pos;
        set_vec = '0;
        clr_vec = '0;
        pos     = '0;
        for (int l = 0; l < ENCODER_COUNT; l++)
        begin
            for (int w = 0; w < BTN_PER_LANE; w++)
            begin
                pos = POS_W'(first_bit) + POS_W'(BTN_PER_LANE * l + w);
                // Positions past the top of the mask are dropped.
                if (pos < POS_W'(MASK_W))
                begin
                    set_vec[pos[$clog2(MASK_W)-1:0]] = set_vec[pos[$clog2(MASK_W)-1:0]]
                                                       | results[l].set[w];
                    clr_vec[pos[$clog2(MASK_W)-1:0]] = clr_vec[pos[$clog2(MASK_W)-1:0]]
                                                       | results[l].clr[w];
                end
            end
        end
    end

    assign mask_next = (mask_cur & ~clr_vec) | set_vec;

endmodule

// ----- src/rotary_detent_button_pulser.sv -----
// ----------------------------------------------------------------------------
// rotary_detent_button_pulser
// Rotary encoder detent decoder with debounce, producing a button mask.
// ----------------------------------------------------------------------------
// Each input transfer is one poll of all encoders with a millisecond time
// stamp; each poll yields one output transfer carrying the full 32-bit button
// mask after that poll. A poll is taken every clock cycle while the output
// side keeps up, and its mask is registered for the next cycle. That rate is
// set by the per-encoder state update, combinational in every lane (32-bit
// elapsed-time subtracts and compares), followed by the mask merge.
// Encoder i owns mask bits first_button_bit + 3i (clockwise), +1
// (counterclockwise) and +2 (push); bits beyond 31 are dropped. Configuration
// writes should be made while no transfer is pending.
// ----------------------------------------------------------------------------
module rotary_detent_button_pulser
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [rdbp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rdbp_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Poll stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // clk_levels[4:0], dt_levels[9:5], press_levels[14:10], now_ms[46:15], zero[47]
    input  logic [rdbp_pkg::IN_DATA_W-1:0]      s_tdata,
    // Mask stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // button_bits[31:0]
    output logic [rdbp_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import rdbp_pkg::*;

    cfg_t              cfg_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] mask_next;
    logic              m_valid_reg;
    logic              in_xfer;

    logic [LEVEL_W-1:0] clk_levels;
    logic [LEVEL_W-1:0] dt_levels;
    logic [LEVEL_W-1:0] press_levels;
    logic [TIME_W-1:0]  now_ms;

    lane_result_t lane_results [ENCODER_COUNT];

    assign clk_levels   = s_tdata[LEVEL_W-1:0];
    assign dt_levels    = s_tdata[2*LEVEL_W-1:LEVEL_W];
    assign press_levels = s_tdata[3*LEVEL_W-1:2*LEVEL_W];
    assign now_ms       = s_tdata[3*LEVEL_W+TIME_W-1:3*LEVEL_W];

    assign s_tready = !m_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.edge_db   <= EDGE_DB_W'(5);
            cfg_reg.press_db  <= PRESS_DB_W'(50);
            cfg_reg.pulse_len <= PULSE_LEN_W'(50);
            cfg_reg.first_bit <= FIRST_BIT_W'(10);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_EDGE_DB:   cfg_reg.edge_db   <= cfg_data[EDGE_DB_W-1:0];
                CFG_PRESS_DB:  cfg_reg.press_db  <= cfg_data[PRESS_DB_W-1:0];
                CFG_PULSE_LEN: cfg_reg.pulse_len <= cfg_data[PULSE_LEN_W-1:0];
                CFG_FIRST_BIT: cfg_reg.first_bit <= cfg_data[FIRST_BIT_W-1:0];
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < ENCODER_COUNT; g++)
        begin : g_lane
            logic lane_clk;
            logic lane_dt;
            logic lane_btn;

            // Lanes past the width of the level fields see all pins low.
            if (g < LEVEL_W)
            begin : g_pins
                assign lane_clk = clk_levels[g];
                assign lane_dt  = dt_levels[g];
                assign lane_btn = press_levels[g];
            end
            else
            begin : g_nopins
                assign lane_clk = 1'b0;
                assign lane_dt  = 1'b0;
                assign lane_btn = 1'b0;
            end

            rdbp_lane u_lane
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (in_xfer),
                .clk_lvl (lane_clk),
                .dt_lvl  (lane_dt),
                .btn_lvl (lane_btn),
                .now_ms  (now_ms),
                .cfg     (cfg_reg),
                .result  (lane_results[g])
            );
        end
    endgenerate

    rdbp_merge u_merge
    (
        .results   (lane_results),
        .first_bit (cfg_reg.first_bit),
        .mask_cur  (mask_reg),
        .mask_next (mask_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                mask_reg    <= mask_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule
